// ===== sv/plbbs_pkg.sv =====
// ----------------------------------------------------------------------------
// plbbs_pkg: shared types and constants of the priority LRU byte budget store
// Command codes, result codes, datapath operation codes and the control
// interface structs between controller and datapath.
// ----------------------------------------------------------------------------
package plbbs_pkg;

    // field widths fixed by the stream format
    localparam int CMD_W   = 3;
    localparam int ID_W    = 16;
    localparam int COST_W  = 32;
    localparam int RANK_W  = 2;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 5;
    localparam int HELD_W  = 36;

    localparam logic [COST_W-1:0] DEFAULT_BUDGET = 32'd67108864;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ACCESS  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TRIM    = 3'd5;

    // result status codes
    localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] ST_REJECT   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

    // rank codes
    localparam logic [RANK_W-1:0] RANK_BACKGROUND = 2'd0;
    localparam logic [RANK_W-1:0] RANK_ILLEGAL    = 2'd3;

    // datapath operations
    typedef logic [3:0] op_t;
    localparam op_t OP_NONE       = 4'd0;
    localparam op_t OP_LOAD       = 4'd1;
    localparam op_t OP_REJECT     = 4'd2;
    localparam op_t OP_NOTFOUND   = 4'd3;
    localparam op_t OP_UPDATE     = 4'd4;
    localparam op_t OP_ACCESS     = 4'd5;
    localparam op_t OP_RELEASE    = 4'd6;
    localparam op_t OP_CLEAR      = 4'd7;
    localparam op_t OP_SCAN_START = 4'd8;
    localparam op_t OP_SCAN       = 4'd9;
    localparam op_t OP_EVICT      = 4'd10;
    localparam op_t OP_IDSKIP     = 4'd11;
    localparam op_t OP_STORE      = 4'd12;
    localparam op_t OP_FIN_INS    = 4'd13;
    localparam op_t OP_OUT        = 4'd14;

    typedef struct packed {
        op_t  op;
        logic key_handle;   // id match against next handle instead of entry_id
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             cost_bad;
        logic             free_any;
        logic             match_any;
        logic             over_budget;
        logic             scan_last;
        logic             id_ok;
        logic             tries_done;
        logic             out_busy;
    } dp_stat_t;

endpackage

// ===== sv/priority_lru_byte_budget_store.sv =====
// ----------------------------------------------------------------------------
// priority_lru_byte_budget_store: rank-then-age byte budget cache table
// Usage:
//   s_* stream carries one command word: s_tuser is the command code,
//   s_tdata holds entry id, byte cost and requested rank. m_* returns one
//   result word per command: m_tuser is the status, m_tdata the id given,
//   eviction count, byte total, entry count and hit cost.
//   cfg_we/cfg_wdata write the byte budget (zero selects 64 MiB); write
//   only while no command is in flight.
// Sequencing:
//   One command at a time. Release, access, clear and rejects go from decode
//   to the result; update and trim then evict while over budget; insert
//   takes a free slot or evicts for a full table, skips handles in use,
//   stores, then evicts while over budget. Each eviction is a
//   one-slot-per-cycle scan for the lowest rank, oldest stamp.
//   A finished result sits in the output register; the next command is taken
//   while it waits, and a command finishing behind it holds until m_tready.
// Reset: table empty, budget 64 MiB, use clock 0, next handle 1.
// ----------------------------------------------------------------------------
module priority_lru_byte_budget_store
    import plbbs_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int STAMP_BITS = 48
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // entry_id[15:0], byte_cost[47:16], priority_req[49:48]
    input  logic [2:0]  s_tuser,   // cmd[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // assigned_id[15:0], evicted_count[20:16],
                                   // total_bytes[52:21], entry_count[57:53], hit_cost[89:58]
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [ID_W-1:0]   out_assigned;
    logic [CNT_W-1:0]  out_evicted;
    logic [COST_W-1:0] out_total;
    logic [CNT_W-1:0]  out_count;
    logic [COST_W-1:0] out_hit;

    // sequencer
    plbbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table and arithmetic
    plbbs_dp #(
        .ENTRIES    (ENTRIES),
        .STAMP_BITS (STAMP_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_cmd       (s_tuser),
        .in_id        (s_tdata[15:0]),
        .in_cost      (s_tdata[47:16]),
        .in_rank      (s_tdata[49:48]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (m_tuser),
        .out_assigned (out_assigned),
        .out_evicted  (out_evicted),
        .out_total    (out_total),
        .out_count    (out_count),
        .out_hit      (out_hit)
    );

    // result word packing
    assign m_tdata = {6'd0, out_hit, out_count, out_total, out_evicted, out_assigned};

endmodule

// ===== sv/plbbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// plbbs_ctrl: command sequencer
// Walks each command through decode, victim scans, evictions, id
// allocation and result hand-off, driving the datapath one op per cycle.
// ----------------------------------------------------------------------------
module plbbs_ctrl
    import plbbs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_VSCAN  = 3'd2;
    localparam logic [2:0] S_EVICT  = 3'd3;
    localparam logic [2:0] S_IDGEN  = 3'd4;
    localparam logic [2:0] S_TCHK   = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       full_reg, full_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and op
    always_comb
    begin
        state_next     = state_reg;
        full_next      = full_reg;
        cmd.op         = OP_NONE;
        cmd.key_handle = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.cmd)
                    CMD_INSERT:
                    begin
                        if (stat.cost_bad)
                        begin
                            cmd.op     = OP_REJECT;
                            state_next = S_DONE;
                        end
                        else if (stat.free_any)
                        begin
                            state_next = S_IDGEN;
                        end
                        else
                        begin
                            cmd.op     = OP_SCAN_START;
                            full_next  = 1'b1;
                            state_next = S_VSCAN;
                        end
                    end
                    CMD_UPDATE, CMD_ACCESS, CMD_RELEASE:
                    begin
                        if (!stat.match_any)
                        begin
                            cmd.op     = OP_NOTFOUND;
                            state_next = S_DONE;
                        end
                        else if (stat.cmd == CMD_UPDATE)
                        begin
                            cmd.op     = OP_UPDATE;
                            state_next = S_TCHK;
                        end
                        else
                        begin
                            cmd.op     = (stat.cmd == CMD_ACCESS) ? OP_ACCESS : OP_RELEASE;
                            state_next = S_DONE;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        cmd.op     = OP_CLEAR;
                        state_next = S_DONE;
                    end
                    CMD_TRIM:
                    begin
                        state_next = S_TCHK;
                    end
                    default:
                    begin
                        cmd.op     = OP_REJECT;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_TCHK:
            begin
                if (stat.over_budget)
                begin
                    cmd.op     = OP_SCAN_START;
                    full_next  = 1'b0;
                    state_next = S_VSCAN;
                end
                else
                begin
                    state_next = (stat.cmd == CMD_INSERT) ? S_FIN : S_DONE;
                end
            end
            S_VSCAN:
            begin
                cmd.op = OP_SCAN;
                if (stat.scan_last)
                    state_next = S_EVICT;
            end
            S_EVICT:
            begin
                cmd.op     = OP_EVICT;
                state_next = full_reg ? S_IDGEN : S_TCHK;
            end
            S_IDGEN:
            begin
                cmd.key_handle = 1'b1;
                if (stat.tries_done)
                begin
                    cmd.op     = OP_REJECT;
                    state_next = S_DONE;
                end
                else if (stat.id_ok)
                begin
                    cmd.op     = OP_STORE;
                    state_next = S_TCHK;
                end
                else
                begin
                    cmd.op = OP_IDSKIP;
                end
            end
            S_FIN:
            begin
                cmd.op     = OP_FIN_INS;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            full_reg  <= full_next;
        end
    end

endmodule

// ===== sv/plbbs_dp.sv =====
// ----------------------------------------------------------------------------
// plbbs_dp: slot table and arithmetic
// Holds the slots, use clock, handle counter, byte total, budget register,
// the victim scan unit and the result register.
// ----------------------------------------------------------------------------
module plbbs_dp
    import plbbs_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int STAMP_BITS = 48
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    input  logic              cfg_we,
    input  logic [COST_W-1:0] cfg_wdata,
    input  logic [CMD_W-1:0]  in_cmd,
    input  logic [ID_W-1:0]   in_id,
    input  logic [COST_W-1:0] in_cost,
    input  logic [RANK_W-1:0] in_rank,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [STAT_W-1:0] out_status,
    output logic [ID_W-1:0]   out_assigned,
    output logic [CNT_W-1:0]  out_evicted,
    output logic [COST_W-1:0] out_total,
    output logic [CNT_W-1:0]  out_count,
    output logic [COST_W-1:0] out_hit
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int TW = $clog2(ENTRIES + 2);
    localparam int VW = $clog2(ENTRIES + 1);
    localparam logic [HELD_W-1:0] HELD_MAX = {HELD_W{1'b1}};

    // slot table
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic [ID_W-1:0]       slot_id   [ENTRIES];
    logic [COST_W-1:0]     slot_cost [ENTRIES];
    logic [STAMP_BITS-1:0] slot_stamp[ENTRIES];
    logic [RANK_W-1:0]     slot_rank [ENTRIES];

    // control state
    logic [STAMP_BITS-1:0] clock_reg, clock_next;
    logic [ID_W-1:0]       handle_reg, handle_next;
    logic [HELD_W-1:0]     held_reg, held_next;
    logic [COST_W-1:0]     budget_reg, budget_next;
    logic [TW-1:0]         tries_reg, tries_next;
    logic [IW-1:0]         scan_reg, scan_next;
    logic                  bestv_reg, bestv_next;
    logic [IW-1:0]         besti_reg, besti_next;
    logic [RANK_W-1:0]     bestr_reg, bestr_next;
    logic [STAMP_BITS-1:0] bests_reg, bests_next;
    logic                  ovalid_reg, ovalid_next;

    // latched command and result words
    logic [CMD_W-1:0]  cmd_reg;
    logic [ID_W-1:0]   eid_reg;
    logic [COST_W-1:0] cost_reg;
    logic [RANK_W-1:0] rank_reg;
    logic [STAT_W-1:0] rstat_reg, rstat_next;
    logic [ID_W-1:0]   rassn_reg, rassn_next;
    logic [CNT_W-1:0]  rev_reg, rev_next;
    logic [COST_W-1:0] rhit_reg, rhit_next;
    logic [IW-1:0]     ins_slot_reg;
    logic [ID_W-1:0]   ins_id_reg;
    logic [STAT_W-1:0] ostat_reg;
    logic [ID_W-1:0]   oassn_reg;
    logic [CNT_W-1:0]  oev_reg;
    logic [COST_W-1:0] ototal_reg;
    logic [CNT_W-1:0]  ocount_reg;
    logic [COST_W-1:0] ohit_reg;

    // id match across all slots
    logic [ID_W-1:0]    key;
    logic [ENTRIES-1:0] match_vec;
    logic               match_any;
    logic [IW-1:0]      match_idx;
    logic               free_any;
    logic [IW-1:0]      free_idx;
    logic [VW-1:0]      vcount;

    assign key = cmd.key_handle ? handle_reg : eid_reg;

    always_comb
    begin
        match_any = 1'b0;
        match_idx = '0;
        free_any  = 1'b0;
        free_idx  = '0;
        vcount    = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            match_vec[i] = valid_reg[i] && (slot_id[i] == key);
            if (match_vec[i])
                match_idx = IW'(i);
            if (!valid_reg[i])
                free_idx = IW'(i);
            vcount = vcount + VW'(valid_reg[i]);
        end
        match_any = |match_vec;
        free_any  = ~&valid_reg;
    end

    // budget and compares
    logic [COST_W-1:0] eff_budget;
    logic              over_budget;
    assign eff_budget  = (budget_reg == '0) ? DEFAULT_BUDGET : budget_reg;
    assign over_budget = (held_reg > HELD_W'(eff_budget)) && (|valid_reg);

    // victim scan compare at the scan index
    logic scan_better;
    assign scan_better = valid_reg[scan_reg] &&
                         (!bestv_reg || (slot_rank[scan_reg] < bestr_reg) ||
                          ((slot_rank[scan_reg] == bestr_reg) &&
                           (slot_stamp[scan_reg] < bests_reg)));

    // slot drop: release hits the matched slot, eviction the best victim
    logic [IW-1:0]      drop_idx;
    logic [COST_W-1:0]  drop_cost;
    logic [ENTRIES-1:0] drop_valid;
    logic [HELD_W-1:0]  drop_held;
    assign drop_idx   = (cmd.op == OP_RELEASE) ? match_idx : besti_reg;
    assign drop_cost  = slot_cost[drop_idx];
    assign drop_valid = valid_reg & ~(ENTRIES'(1) << drop_idx);
    assign drop_held  = (drop_valid == '0) ? '0 :
                        (held_reg >= HELD_W'(drop_cost)) ? held_reg - HELD_W'(drop_cost) : '0;

    // handle advance, wrap skips zero
    logic [ID_W-1:0] handle_inc;
    assign handle_inc = (handle_reg + 1'b1 == '0) ? ID_W'(1) : handle_reg + 1'b1;

    logic [HELD_W:0] held_sum;
    assign held_sum = {1'b0, held_reg} + (HELD_W + 1)'(cost_reg);

    logic [STAMP_BITS-1:0] clock_inc;
    assign clock_inc = clock_reg + 1'b1;

    // status to controller
    assign stat.cmd         = cmd_reg;
    assign stat.cost_bad    = (cost_reg == '0) || (cost_reg > eff_budget);
    assign stat.free_any    = free_any;
    assign stat.match_any   = match_any && (eid_reg != '0);
    assign stat.over_budget = over_budget;
    assign stat.scan_last   = (scan_reg == IW'(ENTRIES - 1));
    assign stat.id_ok       = (handle_reg != '0) && !match_any;
    assign stat.tries_done  = (tries_reg == TW'(ENTRIES + 1));
    assign stat.out_busy    = ovalid_reg && !out_ready;

    // control next values
    always_comb
    begin
        valid_next  = valid_reg;
        clock_next  = clock_reg;
        handle_next = handle_reg;
        held_next   = held_reg;
        budget_next = cfg_we ? cfg_wdata : budget_reg;
        tries_next  = tries_reg;
        scan_next   = scan_reg;
        bestv_next  = bestv_reg;
        besti_next  = besti_reg;
        bestr_next  = bestr_reg;
        bests_next  = bests_reg;
        rstat_next  = rstat_reg;
        rassn_next  = rassn_reg;
        rev_next    = rev_reg;
        rhit_next   = rhit_reg;
        ovalid_next = (ovalid_reg && out_ready) ? 1'b0 : ovalid_reg;
        unique case (cmd.op)
            OP_LOAD:
            begin
                rstat_next = ST_DONE;
                rassn_next = '0;
                rev_next   = '0;
                rhit_next  = '0;
                tries_next = '0;
            end
            OP_REJECT:   rstat_next = ST_REJECT;
            OP_NOTFOUND: rstat_next = ST_NOTFOUND;
            OP_UPDATE:   clock_next = clock_inc;
            OP_ACCESS:
            begin
                clock_next = clock_inc;
                rhit_next  = slot_cost[match_idx];
            end
            OP_RELEASE:
            begin
                valid_next = drop_valid;
                held_next  = drop_held;
            end
            OP_CLEAR:
            begin
                valid_next = '0;
                held_next  = '0;
            end
            OP_SCAN_START:
            begin
                scan_next  = '0;
                bestv_next = 1'b0;
            end
            OP_SCAN:
            begin
                scan_next = scan_reg + 1'b1;
                if (scan_better)
                begin
                    bestv_next = 1'b1;
                    besti_next = scan_reg;
                    bestr_next = slot_rank[scan_reg];
                    bests_next = slot_stamp[scan_reg];
                end
            end
            OP_EVICT:
            begin
                valid_next = drop_valid;
                held_next  = drop_held;
                rev_next   = (rev_reg == '1) ? rev_reg : rev_reg + 1'b1;
            end
            OP_IDSKIP:
            begin
                handle_next = handle_inc;
                tries_next  = tries_reg + 1'b1;
            end
            OP_STORE:
            begin
                handle_next         = handle_inc;
                tries_next          = tries_reg + 1'b1;
                valid_next[free_idx] = 1'b1;
                clock_next          = clock_inc;
                held_next           = held_sum[HELD_W] ? HELD_MAX : held_sum[HELD_W-1:0];
            end
            OP_FIN_INS:
            begin
                if (valid_reg[ins_slot_reg])
                    rassn_next = ins_id_reg;
                else
                    rstat_next = ST_REJECT;
            end
            OP_OUT:      ovalid_next = 1'b1;
            default:     ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            clock_reg  <= '0;
            handle_reg <= ID_W'(1);
            held_reg   <= '0;
            budget_reg <= DEFAULT_BUDGET;
            tries_reg  <= '0;
            scan_reg   <= '0;
            bestv_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            clock_reg  <= clock_next;
            handle_reg <= handle_next;
            held_reg   <= held_next;
            budget_reg <= budget_next;
            tries_reg  <= tries_next;
            scan_reg   <= scan_next;
            bestv_reg  <= bestv_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        besti_reg <= besti_next;
        bestr_reg <= bestr_next;
        bests_reg <= bests_next;
        rstat_reg <= rstat_next;
        rassn_reg <= rassn_next;
        rev_reg   <= rev_next;
        rhit_reg  <= rhit_next;
        if (cmd.op == OP_LOAD)
        begin
            cmd_reg  <= in_cmd;
            eid_reg  <= in_id;
            cost_reg <= in_cost;
            rank_reg <= (in_rank == RANK_ILLEGAL) ? RANK_BACKGROUND : in_rank;
        end
        if (cmd.op == OP_UPDATE)
        begin
            slot_rank[match_idx]  <= rank_reg;
            slot_stamp[match_idx] <= clock_inc;
        end
        if (cmd.op == OP_ACCESS)
            slot_stamp[match_idx] <= clock_inc;
        if (cmd.op == OP_STORE)
        begin
            slot_id[free_idx]    <= handle_reg;
            slot_cost[free_idx]  <= cost_reg;
            slot_stamp[free_idx] <= clock_inc;
            slot_rank[free_idx]  <= rank_reg;
            ins_slot_reg         <= free_idx;
            ins_id_reg           <= handle_reg;
        end
        if (cmd.op == OP_OUT)
        begin
            ostat_reg  <= rstat_reg;
            oassn_reg  <= rassn_reg;
            oev_reg    <= rev_reg;
            ototal_reg <= (held_reg[HELD_W-1:COST_W] != '0) ? '1 : held_reg[COST_W-1:0];
            ocount_reg <= CNT_W'(vcount);
            ohit_reg   <= rhit_reg;
        end
    end

    assign out_valid    = ovalid_reg;
    assign out_status   = ostat_reg;
    assign out_assigned = oassn_reg;
    assign out_evicted  = oev_reg;
    assign out_total    = ototal_reg;
    assign out_count    = ocount_reg;
    assign out_hit      = ohit_reg;

endmodule
